// File: src/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, the sequencer state type and the structs passed between the
// cell row and the top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int PORT_BITS  = 32;
   localparam int VALUE_BITS = 32;
   // Only the low bits of the key port that fit in KEY_BITS are compared.
   localparam int KEY_USE    = (KEY_BITS < PORT_BITS) ? KEY_BITS : PORT_BITS;
   localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_PUT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Broadcast to every cell for one update cycle.
   typedef struct packed {
      logic                  update;
      logic                  age_all;
      logic [RANK_BITS-1:0]  old_rank;
      logic                  write_key;
      logic                  write_value;
      logic [KEY_USE-1:0]    key;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   // Outcome of one parallel compare over the row.
   typedef struct packed {
      logic                  hit;
      logic                  full;
      logic [RANK_BITS-1:0]  hit_rank;
      logic [VALUE_BITS-1:0] hit_value;
      logic [ENTRIES-1:0]    match_vec;
      logic [ENTRIES-1:0]    victim_vec;
   } status_type;

endpackage
`default_nettype wire

// File: src/lkvc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache channels
// Request and response handshake channels carrying valid, ready and payload.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [lkvc_pkg::PORT_BITS-1:0]  key;
   logic [lkvc_pkg::VALUE_BITS-1:0] value_in;

   modport source (output valid, output mode, output key, output value_in, input ready);
   modport sink   (input valid, input mode, input key, input value_in, output ready);
endinterface

interface lkvc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [lkvc_pkg::VALUE_BITS-1:0] value_out;
   logic                            evicted;

   modport source (output valid, output hit, output value_out, output evicted, input ready);
   modport sink   (input valid, input hit, input value_out, input evicted, output ready);
endinterface
`default_nettype wire

// File: src/lkvc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One cache slot: key, value, recency rank and valid flag, with its own
// compare and ageing logic.
// ----------------------------------------------------------------------------
module lkvc_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lkvc_pkg::cmd_type               cmd,
   input  wire logic                            sel,
   input  wire logic                            prev_valid,
   input  wire logic [lkvc_pkg::KEY_USE-1:0]    probe_key,
   output      logic                            valid,
   output      logic                            match,
   output      logic                            lru,
   output      logic                            first_free,
   output      logic [lkvc_pkg::RANK_BITS-1:0]  rank,
   output      logic [lkvc_pkg::VALUE_BITS-1:0] value
);

   logic                            valid_ff, valid_in;
   logic [lkvc_pkg::RANK_BITS-1:0]  rank_ff, rank_in;
   logic [lkvc_pkg::KEY_USE-1:0]    key_ff, key_in;
   logic [lkvc_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                            age;

   assign valid      = valid_ff;
   assign rank       = rank_ff;
   assign value      = value_ff;
   assign match      = valid_ff && (key_ff == probe_key);
   assign lru        = valid_ff &&
                       (rank_ff == lkvc_pkg::RANK_BITS'(lkvc_pkg::ENTRIES - 1));
   // The free slots form a tail of the row, so the first one follows a valid neighbour.
   assign first_free = prev_valid && !valid_ff;
   assign age        = valid_ff && (cmd.age_all || (rank_ff < cmd.old_rank));

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.update) begin
         if (sel) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (cmd.write_key) begin
               key_in = cmd.key;
            end
            if (cmd.write_value) begin
               value_in = cmd.value;
            end
         end else if (age) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// File: src/lkvc_cell_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache cell row
// Chains the cells through their valid flags and gathers the compare results.
// ----------------------------------------------------------------------------
module lkvc_cell_row (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lkvc_pkg::cmd_type                  cmd,
   input  wire logic [lkvc_pkg::ENTRIES-1:0]       sel_vec,
   input  wire logic [lkvc_pkg::KEY_USE-1:0]       probe_key,
   output      lkvc_pkg::status_type               status
);

   logic [lkvc_pkg::ENTRIES-1:0]    valid_vec, match_vec, lru_vec, free_vec;
   logic [lkvc_pkg::ENTRIES-1:0]    prev_valid_vec;
   logic [lkvc_pkg::RANK_BITS-1:0]  rank_arr  [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VALUE_BITS-1:0] value_arr [lkvc_pkg::ENTRIES];

   assign prev_valid_vec = {valid_vec[lkvc_pkg::ENTRIES-2:0], 1'b1};

   for (genvar i = 0; i < lkvc_pkg::ENTRIES; i++) begin : g_cell
      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (sel_vec[i]),
         .prev_valid (prev_valid_vec[i]),
         .probe_key  (probe_key),
         .valid      (valid_vec[i]),
         .match      (match_vec[i]),
         .lru        (lru_vec[i]),
         .first_free (free_vec[i]),
         .rank       (rank_arr[i]),
         .value      (value_arr[i])
      );
   end

   // Valid keys are unique, so at most one cell matches and a plain OR selects.
   always_comb begin
      status.hit       = |match_vec;
      status.full      = valid_vec[lkvc_pkg::ENTRIES-1];
      status.match_vec = match_vec;
      status.victim_vec = valid_vec[lkvc_pkg::ENTRIES-1] ? lru_vec : free_vec;
      status.hit_rank  = '0;
      status.hit_value = '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         status.hit_rank  = status.hit_rank  | (rank_arr[i]  & {lkvc_pkg::RANK_BITS{match_vec[i]}});
         status.hit_value = status.hit_value | (value_arr[i] & {lkvc_pkg::VALUE_BITS{match_vec[i]}});
      end
   end

endmodule
`default_nettype wire

// File: src/lru_key_value_cache_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative cache with true least-recently-used replacement, built
// as a row of slot cells that compare a key in parallel and age themselves.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Carries                          Beat taken when
//   req      in   mode, key, value_in              req.valid && req.ready
//   rsp      out  hit, value_out, evicted          rsp.valid && rsp.ready
//
// A request passes through the idle state that takes the beat, a lookup state
// for the parallel key compare, and an update state in which the selected cell
// is written and the more recent cells age; a lookup miss leaves the row as is.
// The update state stalls while an earlier response beat is held with rsp.ready
// low; the next request is taken once the update is done. Synchronous reset
// clears every valid flag and rank; keys and values of empty slots stay unreset.
//
module lru_key_value_cache_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   lkvc_req_if.sink     req,
   lkvc_rsp_if.source   rsp
);

   lkvc_pkg::state_type state_ff, state_in;

   // Request held for the duration of the operation.
   logic                            mode_ff;
   logic [lkvc_pkg::KEY_USE-1:0]    key_ff;
   logic [lkvc_pkg::VALUE_BITS-1:0] value_ff;

   // Compare outcome captured at the end of the lookup cycle.
   logic                            hit_ff;
   logic                            full_ff;
   logic [lkvc_pkg::ENTRIES-1:0]    sel_ff;
   logic [lkvc_pkg::RANK_BITS-1:0]  hit_rank_ff;
   logic [lkvc_pkg::VALUE_BITS-1:0] hit_value_ff;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff;
   logic [lkvc_pkg::VALUE_BITS-1:0] rsp_value_ff;
   logic                            rsp_evicted_ff;

   logic                 req_take;
   logic                 capture;
   logic                 finish;
   logic                 rsp_free;
   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req_take = req.valid && req.ready;

   lkvc_cell_row u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sel_vec   (sel_ff),
      .probe_key (key_ff),
      .status    (status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = lkvc_pkg::ST_LOOKUP;
            end
         end
         lkvc_pkg::ST_LOOKUP: begin
            state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (rsp_free) begin
               state_in = lkvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req.ready = 1'b0;
      capture   = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         lkvc_pkg::ST_LOOKUP: begin
            capture = 1'b1;
         end
         lkvc_pkg::ST_UPDATE: begin
            finish = rsp_free;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // Update broadcast: a lookup miss leaves the row untouched. A hit promotes
   // the matching cell; a put miss fills the first free cell (every valid
   // cell ages) or replaces the cell of lowest recency.
   always_comb begin
      cmd.update      = finish && (hit_ff || (mode_ff == lkvc_pkg::MODE_PUT));
      cmd.age_all     = !hit_ff && !full_ff;
      cmd.old_rank    = hit_ff ? hit_rank_ff
                               : lkvc_pkg::RANK_BITS'(lkvc_pkg::ENTRIES - 1);
      cmd.write_key   = !hit_ff;
      cmd.write_value = (mode_ff == lkvc_pkg::MODE_PUT);
      cmd.key         = key_ff;
      cmd.value       = value_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         mode_ff  <= req.mode;
         key_ff   <= req.key[lkvc_pkg::KEY_USE-1:0];
         value_ff <= req.value_in;
      end
      if (capture) begin
         hit_ff       <= status.hit;
         full_ff      <= status.full;
         sel_ff       <= status.hit ? status.match_vec : status.victim_vec;
         hit_rank_ff  <= status.hit_rank;
         hit_value_ff <= status.hit_value;
      end
      if (finish) begin
         rsp_hit_ff     <= hit_ff;
         rsp_value_ff   <= (hit_ff && (mode_ff == lkvc_pkg::MODE_LOOKUP)) ? hit_value_ff : '0;
         rsp_evicted_ff <= !hit_ff && full_ff && (mode_ff == lkvc_pkg::MODE_PUT);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.value_out = rsp_value_ff;
   assign rsp.evicted   = rsp_evicted_ff;

endmodule
`default_nettype wire

// File: test/lkvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Watches the request and response channels, keeps its own copy of the
// cache contents and recency order, and compares every response beat with
// the outcome it predicts.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input  wire logic clock,
   input  wire logic reset,
   lkvc_req_if       req,
   lkvc_rsp_if       rsp,
   output int        failures,
   output int        pending
);
   import lkvc_pkg::*;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] value;
      logic                  evicted;
   } outcome_type;

   logic [KEY_USE-1:0]    slot_key   [ENTRIES];
   logic [VALUE_BITS-1:0] slot_value [ENTRIES];
   logic [RANK_BITS-1:0]  slot_rank  [ENTRIES];
   int                    fill_slots;
   outcome_type           awaited_outcomes [$];

   // Applies one request to the cache copy and returns its outcome.
   function automatic outcome_type apply_request(input logic                  mode,
                                                 input logic [PORT_BITS-1:0]  key_word,
                                                 input logic [VALUE_BITS-1:0] value);
      logic [KEY_USE-1:0] key_cut;
      outcome_type        outcome;
      int                 slot;
      int                 old_rank;
      bit                 found;
      key_cut  = key_word[KEY_USE-1:0];
      outcome  = '0;
      slot     = 0;
      old_rank = 0;
      found    = 1'b0;
      for (int i = 0; i < fill_slots; i++) begin
         if (!found && slot_key[i] == key_cut) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         outcome.hit = 1'b1;
         if (mode == MODE_LOOKUP) begin
            outcome.value = slot_value[slot];
         end else begin
            slot_value[slot] = value;
         end
         old_rank = slot_rank[slot];
      end else if (mode == MODE_PUT) begin
         if (fill_slots < ENTRIES) begin
            // A fresh slot counts as older than everything, so all others age.
            slot       = fill_slots;
            fill_slots = fill_slots + 1;
            old_rank   = ENTRIES;
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && slot_rank[i] == ENTRIES - 1) begin
                  slot  = i;
                  found = 1'b1;
               end
            end
            old_rank        = ENTRIES - 1;
            outcome.evicted = 1'b1;
         end
         slot_key[slot]   = key_cut;
         slot_value[slot] = value;
      end else begin
         return outcome;
      end
      for (int i = 0; i < fill_slots; i++) begin
         if (i != slot && slot_rank[i] < old_rank) begin
            slot_rank[i] = slot_rank[i] + 1'b1;
         end
      end
      slot_rank[slot] = '0;
      return outcome;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         fill_slots = 0;
         failures   = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_rank[i] = '0;
         end
         awaited_outcomes.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: response beat with no request outstanding", $time);
               failures = failures + 1;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp.hit !== want.hit) begin
                  $display("%0t: hit expected %0b got %0b", $time, want.hit, rsp.hit);
                  failures = failures + 1;
               end
               if (rsp.value_out !== want.value) begin
                  $display("%0t: value_out expected %h got %h", $time, want.value,
                           rsp.value_out);
                  failures = failures + 1;
               end
               if (rsp.evicted !== want.evicted) begin
                  $display("%0t: evicted expected %0b got %0b", $time, want.evicted,
                           rsp.evicted);
                  failures = failures + 1;
               end
            end
         end
         if (req.valid && req.ready) begin
            awaited_outcomes.push_back(apply_request(req.mode, req.key, req.value_in));
         end
      end
      pending = awaited_outcomes.size();
   end

endmodule

// File: test/tb_lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache unit testbench
// Drives lookups and puts into the cache with random gaps, accepts responses
// with random stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
   import lkvc_pkg::*;

   logic clock;
   logic reset;

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   int failures;
   int pending;

   // Upper bounds for the per-beat idle draws; a bound of zero gives a stretch
   // in which that side never idles.
   int gap_limit;
   int stall_limit;

   // Keys are mostly drawn from a small pool so that hits, refreshes and
   // evictions are frequent; the pool size decides how often the cache spills.
   logic [PORT_BITS-1:0] key_pool [64];
   int                   pool_size;

   lru_key_value_cache_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   lkvc_checker cache_check (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Response side: before every beat it draws a random stall, during which ready
   // is held low, then keeps ready high until the beat has been taken.
   // Only one assignment to ready is made in any one time step.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, stall_limit);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Sends one request beat after a random gap and returns at the edge at
   // which it was accepted, leaving valid high for the caller to continue.
   task automatic send_request(input logic                  mode,
                               input logic [PORT_BITS-1:0]  key_word,
                               input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= mode;
      req_bus.key      <= key_word;
      req_bus.value_in <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops sending and waits until every predicted response has arrived.
   // The pending count is read only once the checker has sampled the channels, so it has seen the last beat.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_phase(input int count, input int keys_in_pool);
      logic mode;
      logic [PORT_BITS-1:0] key_word;
      pool_size = keys_in_pool;
      for (int i = 0; i < pool_size; i++) begin
         key_pool[i] = $urandom();
      end
      for (int n = 0; n < count; n++) begin
         mode = ($urandom_range(0, 1) != 0) ? MODE_PUT : MODE_LOOKUP;
         // One beat in ten carries a completely fresh key.
         if ($urandom_range(0, 9) == 0) begin
            key_word = $urandom();
         end else begin
            key_word = key_pool[$urandom_range(0, pool_size - 1)];
         end
         send_request(mode, key_word, $urandom());
      end
   endtask

   initial begin
      gap_limit        = 3;
      stall_limit      = 3;
      pool_size        = 1;
      reset            = 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_LOOKUP;
      req_bus.key      <= '0;
      req_bus.value_in <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A lookup on the empty cache misses, then the two
      // extreme keys are stored with extreme values.
      send_request(MODE_LOOKUP, '0, 32'hFFFF_FFFF);
      send_request(MODE_PUT, '0, 32'hFFFF_FFFF);
      send_request(MODE_PUT, 32'hFFFF_FFFF, '0);
      // A put that hits the most recent entry only rewrites its value.
      send_request(MODE_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(MODE_LOOKUP, '0, '0);
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
      // Fill the remaining free slots; key zero is then the least recent.
      for (int i = 1; i <= ENTRIES - 2; i++) begin
         send_request(MODE_PUT, PORT_BITS'(i), 32'hA5A5_0000 + i);
      end
      // A miss on a full cache replaces the least recent entry.
      send_request(MODE_PUT, 32'h0000_0100, 32'h5A5A_5A5A);
      send_request(MODE_LOOKUP, '0, '0);
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
      send_request(MODE_PUT, '0, 32'h8000_0001);

      // Hold the sender back until the directed beats have all been answered.
      drain_responses();

      // Random part: each phase changes the pool size and the idle pattern,
      // including stretches where one or both sides never idle.
      gap_limit   = 10;
      stall_limit = 10;
      random_phase(300, 8);
      gap_limit   = 0;
      stall_limit = 0;
      random_phase(300, 17);
      drain_responses();
      gap_limit   = 10;
      stall_limit = 0;
      random_phase(300, 24);
      gap_limit   = 0;
      stall_limit = 10;
      random_phase(300, 16);
      drain_responses();
      gap_limit   = 10;
      stall_limit = 10;
      random_phase(300, 40);
      gap_limit   = 2;
      stall_limit = 2;
      random_phase(300, 12);

      drain_responses();
      // Let any late, unexpected beat show up before the verdict.
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
